[sv/adbk_pkg.sv]
`timescale 1ns / 1ps

package adbk_pkg;

  // Default number of key event slots in the event queue.
  localparam int QUEUE_DEPTH_DEFAULT = 16;

  // Bus request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_KEY_EVENT = 3'd0,
    REQ_TALK_R0   = 3'd1,
    REQ_TALK_R2   = 3'd2,
    REQ_LISTEN_R2 = 3'd3,
    REQ_TALK_R3   = 3'd4,
    REQ_LISTEN_R3 = 3'd5
  } req_code_t;

  // Second listen byte codes for register 3.
  localparam logic [7:0] R3_MOVE         = 8'h00;
  localparam logic [7:0] R3_HANDLER_STD  = 8'h01;
  localparam logic [7:0] R3_HANDLER_EXT  = 8'h02;
  localparam logic [7:0] R3_GUARDED_MOVE = 8'hFE;

  // Handler id that reports the right-hand modifier keys as themselves.
  localparam logic [7:0] HANDLER_RIGHT_KEYS = 8'h03;

  localparam logic [3:0] RESET_ADDRESS = 4'h2;
  localparam logic [7:0] RESET_HANDLER = 8'h02;

  // Low nibble of the first talk register 3 byte.
  localparam logic [3:0] R3_STATUS_NIBBLE = 4'h3;
  localparam logic [7:0] PAD_BYTE         = 8'hFF;
  localparam logic [1:0] LISTEN_FULL      = 2'd2;

  localparam logic [6:0] KEY_CTRL        = 7'h36;
  localparam logic [6:0] KEY_SHIFT       = 7'h38;
  localparam logic [6:0] KEY_OPTION      = 7'h3A;
  localparam logic [6:0] KEY_RIGHT_SHIFT = 7'h7B;
  localparam logic [6:0] KEY_RIGHT_OPT   = 7'h7C;
  localparam logic [6:0] KEY_RIGHT_CTRL  = 7'h7D;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] key_code;
    logic       key_up;
    logic [7:0] listen_hi;
    logic [7:0] listen_lo;
    logic [1:0] listen_count;
    logic       collision;
  } req_t;

  typedef struct packed {
    logic       replied;
    logic [7:0] reply_hi;
    logic [7:0] reply_lo;
    logic       service_request;
    logic       event_dropped;
  } rsp_t;

  // Occupancy flags of the event queue.
  typedef struct packed {
    logic empty;
    logic full;
    logic two;   // at least two events
    logic many;  // more than two events
  } q_status_t;

  // Turns a stored event into a reply byte, folding the right-hand modifiers
  // onto their left codes unless the handler keeps them apart.
  function automatic logic [7:0] map_event(input logic [7:0] raw, input logic keep_right);
    logic [6:0] code;
    code = raw[6:0];
    if (!keep_right) begin
      if (code == KEY_RIGHT_CTRL) begin
        code = KEY_CTRL;
      end else if (code == KEY_RIGHT_SHIFT) begin
        code = KEY_SHIFT;
      end else if (code == KEY_RIGHT_OPT) begin
        code = KEY_OPTION;
      end
    end
    return {raw[7], code};
  endfunction

endpackage

[sv/adbk_if.sv]
`timescale 1ns / 1ps

// Request channel: key events and bus commands.
interface adbk_req_if;
  logic          valid;
  logic          ready;
  adbk_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Response channel: one word per request.
interface adbk_rsp_if;
  logic          valid;
  logic          ready;
  adbk_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/adb_keyboard_device.sv]
`timescale 1ns / 1ps

// Channel  Role    Payload                                          Accepted when
// -------  ------  -----------------------------------------------  -----------------------
// req      sink    req_type, key_code, key_up, listen_hi/lo,        req.valid & req.ready
//                  listen_count, collision
// rsp      source  replied, reply_hi, reply_lo, service_request,    rsp.valid & rsp.ready
//                  event_dropped
//
// Every request word yields exactly one response word, in the cycle after it is
// accepted. The device takes one request word per cycle while no response is
// stalled; the rate is set by the single response register, which frees in the
// same cycle it is taken. rst is synchronous: the queue empties, the address and
// handler return to two, LEDs and service request clear. Queue storage itself is
// not cleared. While a response word is stalled, req.ready stays low.
module adb_keyboard_device #(
  parameter int QUEUE_DEPTH = adbk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  adbk_req_if.sink    req,
  adbk_rsp_if.source  rsp
);

  // Device registers.
  logic [3:0] bus_address;
  logic [7:0] handler_id;
  logic       srq_pending;
  logic [2:0] led_bits;

  logic [3:0] bus_address_next;
  logic [7:0] handler_id_next;
  logic       srq_pending_next;
  logic [2:0] led_bits_next;

  // Response stage. For a talk to register 0 the reply bytes come from the
  // queue read registers and are finished on the way out.
  logic           rsp_valid;
  adbk_pkg::rsp_t rsp_word;
  logic           rsp_pop;
  logic           rsp_two;
  logic           rsp_keep_right;

  adbk_pkg::rsp_t rsp_word_next;
  logic           accept;
  logic           push;
  logic           pop;
  adbk_pkg::q_status_t q_status;
  logic [7:0]     rd_first;
  logic [7:0]     rd_second;
  adbk_pkg::rsp_t rsp_out;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  adbk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({req.data.key_up, req.data.key_code}),
    .pop       (pop),
    .status    (q_status),
    .rd_first  (rd_first),
    .rd_second (rd_second)
  );

  // Decode the request and work out the next register values and the
  // immediate part of the response.
  always_comb begin
    adbk_pkg::req_code_t code;
    code             = adbk_pkg::req_code_t'(req.data.req_type);
    bus_address_next = bus_address;
    handler_id_next  = handler_id;
    srq_pending_next = srq_pending;
    led_bits_next    = led_bits;
    push             = 1'b0;
    pop              = 1'b0;
    rsp_word_next    = '0;

    unique case (code)
      adbk_pkg::REQ_KEY_EVENT: begin
        if (q_status.full) begin
          rsp_word_next.event_dropped = 1'b1;
        end else begin
          push = accept;
          if (q_status.empty) begin
            srq_pending_next = 1'b1;
          end
        end
      end
      adbk_pkg::REQ_TALK_R0: begin
        if (!q_status.empty) begin
          pop                   = accept;
          rsp_word_next.replied = 1'b1;
          // Up to two events leave, so the queue drains unless more remain.
          if (!q_status.many) begin
            srq_pending_next = 1'b0;
          end
        end
      end
      adbk_pkg::REQ_TALK_R2: begin
        rsp_word_next.replied  = 1'b1;
        rsp_word_next.reply_lo = {5'b0, led_bits};
      end
      adbk_pkg::REQ_LISTEN_R2: begin
        if (req.data.listen_count >= adbk_pkg::LISTEN_FULL) begin
          led_bits_next = req.data.listen_lo[2:0];
        end
      end
      adbk_pkg::REQ_TALK_R3: begin
        rsp_word_next.replied  = 1'b1;
        rsp_word_next.reply_hi = {bus_address, adbk_pkg::R3_STATUS_NIBBLE};
        rsp_word_next.reply_lo = handler_id;
      end
      adbk_pkg::REQ_LISTEN_R3: begin
        if (req.data.listen_count >= adbk_pkg::LISTEN_FULL) begin
          priority if (req.data.listen_lo == adbk_pkg::R3_MOVE) begin
            bus_address_next = req.data.listen_hi[3:0];
            srq_pending_next = req.data.listen_hi[5];
          end else if (req.data.listen_lo == adbk_pkg::R3_HANDLER_STD ||
                       req.data.listen_lo == adbk_pkg::R3_HANDLER_EXT) begin
            handler_id_next = req.data.listen_lo;
          end else if (req.data.listen_lo == adbk_pkg::R3_GUARDED_MOVE) begin
            // An address move only sticks when our last reply got through.
            if (!req.data.collision) begin
              bus_address_next = req.data.listen_hi[3:0];
            end
          end else begin
          end
        end
      end
      default: begin
      end
    endcase

    rsp_word_next.service_request = srq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_address <= adbk_pkg::RESET_ADDRESS;
      handler_id  <= adbk_pkg::RESET_HANDLER;
      srq_pending <= 1'b0;
      led_bits    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        bus_address <= bus_address_next;
        handler_id  <= handler_id_next;
        srq_pending <= srq_pending_next;
        led_bits    <= led_bits_next;
        rsp_valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_word       <= rsp_word_next;
      rsp_pop        <= pop;
      rsp_two        <= q_status.two;
      // The key mapping follows the handler in force when the events left.
      rsp_keep_right <= (handler_id == adbk_pkg::HANDLER_RIGHT_KEYS);
    end
  end

  // Finish a register 0 reply from the popped events; a lone event is
  // followed by the pad byte.
  always_comb begin
    rsp_out = rsp_word;
    if (rsp_pop) begin
      rsp_out.reply_hi = adbk_pkg::map_event(rd_first, rsp_keep_right);
      rsp_out.reply_lo = rsp_two ? adbk_pkg::map_event(rd_second, rsp_keep_right)
                                 : adbk_pkg::PAD_BYTE;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_out;

endmodule

[sv/adbk_queue.sv]
`timescale 1ns / 1ps

// Circular event queue. A pop takes one or two events at once; the popped
// entries are read into registers at the same edge.
module adbk_queue #(
  parameter int DEPTH = adbk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            push_data,
  input  logic                  pop,
  output adbk_pkg::q_status_t   status,
  output logic [7:0]            rd_first,
  output logic [7:0]            rd_second
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [AW-1:0] head_plus1;
  logic [AW-1:0] head_plus2;
  logic [AW-1:0] tail_plus1;
  logic [CW-1:0] count_next;
  logic [AW-1:0] head_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign head_plus1 = wrap_inc(head);
  assign head_plus2 = wrap_inc(head_plus1);
  assign tail_plus1 = wrap_inc(tail);

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
  assign status.two   = (count >= CW'(2));
  assign status.many  = (count > CW'(2));

  always_comb begin
    count_next = count;
    head_next  = head;
    if (push) begin
      count_next = count + 1'b1;
    end else if (pop) begin
      count_next = status.two ? count - CW'(2) : count - 1'b1;
      head_next  = status.two ? head_plus2 : head_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (push) begin
        tail <= tail_plus1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      rd_first  <= mem[head];
      rd_second <= mem[head_plus1];
    end
  end

endmodule

[sv/adbk_checker.sv]
`timescale 1ns / 1ps

module adbk_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input adbk_pkg::rsp_t rsp_data
);

  // Each accepted request word shows up as a response word on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request produced no response word");

  // A pending response word is not withdrawn while stalled.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response word dropped while stalled");

  // Without a reply the reply bytes read as zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.replied) |->
      (rsp_data.reply_hi == 8'h00 && rsp_data.reply_lo == 8'h00))
    else $error("reply bytes set without a reply");

  // A dropped key event never comes with a reply.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.event_dropped) |-> !rsp_data.replied)
    else $error("dropped event flagged on a reply word");

  // Nothing is offered right after reset.
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind adb_keyboard_device adbk_checker u_adbk_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
